FILE: rtl/orl_pkg.sv
// ----------------------------------------------------------------------------
// orl_pkg
// Shared types, constants and helpers for the object record loader.
// ----------------------------------------------------------------------------
package orl_pkg;

  // Width of the location counter and address accumulator (16 to 32).
  localparam int unsigned ADDR_BITS = 24;
  // First column of the data field in a text record (8 to 15).
  localparam int unsigned DATA_START_COLUMN = 12;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned COL_W      = 4;
  localparam int unsigned OUT_ADDR_W = 24;
  localparam int unsigned NAME_LEN   = 6;

  localparam logic [CH_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CH_W-1:0] CH_HEADER    = 8'd72;  // 'H'
  localparam logic [CH_W-1:0] CH_TEXT      = 8'd84;  // 'T'
  localparam logic [CH_W-1:0] CH_END       = 8'd69;  // 'E'
  localparam logic [CH_W-1:0] SEP_RESET    = 8'd94;  // '^'

  localparam logic [COL_W-1:0] COL_ADDR_FIRST = COL_W'(1);
  localparam logic [COL_W-1:0] COL_ADDR_LAST  = COL_W'(1 + NAME_LEN);
  localparam logic [COL_W-1:0] COL_DATA       = COL_W'(DATA_START_COLUMN);

  typedef enum logic [1:0] {
    REC_NONE = 2'd0,
    REC_HEAD = 2'd1,
    REC_TEXT = 2'd2,
    REC_END  = 2'd3
  } rec_t;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_START   = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  typedef struct packed {
    logic                 halted;
    logic [COL_W-1:0]     column;
    rec_t                 record_type;
    logic [ADDR_BITS-1:0] addr_acc;
    logic [ADDR_BITS-1:0] loc_cnt;
    logic [3:0]           high_nibble;
    logic                 nibble_pending;
  } state_t;

  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    logic [OUT_ADDR_W-1:0] address;
    logic [CH_W-1:0]       value;
  } result_t;

  // Hex digit value; anything else counts as zero.
  function automatic logic [3:0] hex_value(input logic [CH_W-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'd48 && c <= 8'd57) v = 4'(c - 8'd48);
    else if (c >= 8'd65 && c <= 8'd70) v = 4'(c - 8'd55);
    else if (c >= 8'd97 && c <= 8'd102) v = 4'(c - 8'd87);
    return v;
  endfunction

  // Fit a location to the result address field.
  function automatic logic [OUT_ADDR_W-1:0] to_out_addr(input logic [ADDR_BITS-1:0] a);
    logic [63:0] wide;
    wide = 64'(a);
    return wide[OUT_ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/orl_step.sv
// ----------------------------------------------------------------------------
// orl_step
// Per-character record parser: next state and optional result for one
// character, given the current parser state and separator code.
// ----------------------------------------------------------------------------
module orl_step (
  input  orl_pkg::state_t              state,
  input  logic [orl_pkg::CH_W-1:0]     ch,
  input  logic [orl_pkg::CH_W-1:0]     sep,
  output orl_pkg::state_t              state_nxt,
  output orl_pkg::result_t             result
);

  logic [3:0]                      digit;
  logic [orl_pkg::ADDR_BITS-1:0]   acc_shift;

  assign digit     = orl_pkg::hex_value(ch);
  assign acc_shift = {state.addr_acc[orl_pkg::ADDR_BITS-5:0], digit};

  always_comb begin
    state_nxt = state;
    result    = '0;
    result.kind = orl_pkg::KIND_WRITE;

    if (!state.halted) begin
      if (ch == orl_pkg::CH_NEWLINE) begin
        // End of line: report the start address of an end record
        if (state.record_type == orl_pkg::REC_END) begin
          result.valid   = 1'b1;
          result.kind    = orl_pkg::KIND_START;
          result.address = orl_pkg::to_out_addr(state.addr_acc);
        end
        state_nxt.column         = '0;
        state_nxt.record_type    = orl_pkg::REC_NONE;
        state_nxt.nibble_pending = 1'b0;
      end else begin
        // Advance column, saturating at the data field
        if (state.column < orl_pkg::COL_DATA) begin
          state_nxt.column = state.column + orl_pkg::COL_W'(1);
        end

        if (state.column == '0) begin
          // Record type character
          state_nxt.addr_acc       = '0;
          state_nxt.nibble_pending = 1'b0;
          if (ch == orl_pkg::CH_HEADER) begin
            state_nxt.record_type = orl_pkg::REC_HEAD;
          end else if (ch == orl_pkg::CH_TEXT) begin
            state_nxt.record_type = orl_pkg::REC_TEXT;
          end else if (ch == orl_pkg::CH_END) begin
            state_nxt.record_type = orl_pkg::REC_END;
          end else begin
            state_nxt.record_type = orl_pkg::REC_NONE;
            state_nxt.halted      = 1'b1;
            result.valid          = 1'b1;
            result.kind           = orl_pkg::KIND_INVALID;
          end
        end else if (state.column > orl_pkg::COL_ADDR_FIRST &&
                     state.column <= orl_pkg::COL_ADDR_LAST) begin
          // Name characters or address digits
          if (state.record_type == orl_pkg::REC_HEAD) begin
            result.valid   = 1'b1;
            result.kind    = orl_pkg::KIND_NAME;
            result.address = orl_pkg::OUT_ADDR_W'(state.column - orl_pkg::COL_W'(2));
            result.value   = ch;
          end else begin
            state_nxt.addr_acc = acc_shift;
            if (state.record_type == orl_pkg::REC_TEXT) begin
              state_nxt.loc_cnt = acc_shift;
            end
          end
        end else if (state.column >= orl_pkg::COL_DATA &&
                     state.record_type == orl_pkg::REC_TEXT) begin
          // Data field: drop separators, pair up hex digits
          if (ch != sep) begin
            if (!state.nibble_pending) begin
              state_nxt.high_nibble    = digit;
              state_nxt.nibble_pending = 1'b1;
            end else begin
              state_nxt.nibble_pending = 1'b0;
              result.valid   = 1'b1;
              result.kind    = orl_pkg::KIND_WRITE;
              result.address = orl_pkg::to_out_addr(state.loc_cnt);
              result.value   = {state.high_nibble, digit};
              state_nxt.loc_cnt = state.loc_cnt + orl_pkg::ADDR_BITS'(1);
            end
          end
        end
      end
    end
  end

endmodule

FILE: rtl/object_record_loader.sv
// ----------------------------------------------------------------------------
// object_record_loader
// Absolute loader for object program text, one character per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch / in_valid / in_ready carries the object text, one character per
//   transaction; a newline ends a line. Each character yields zero or one
//   result on out_kind / out_address / out_value (out_valid / out_ready):
//   a memory write, a program name character, the start address, or an
//   invalid record report. cfg_we / cfg_wdata sets the separator character
//   dropped in text data; write it only while the block is idle.
//   A result appears in the cycle after its input transaction. Throughput is
//   one character per cycle unless the receiver stalls: the parser state
//   updates in the accepting cycle; one result register holds the output.
//   While the receiver stalls with a result held, in_ready drops; it stays
//   high whenever the result register is empty or being drained.
//   After an invalid record the block keeps accepting characters but gives
//   no results until reset. Synchronous reset (rst_n low) clears the parser
//   state and the result register, and restores the separator to '^'.
// ----------------------------------------------------------------------------
module object_record_loader (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [orl_pkg::CH_W-1:0]        in_ch,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_kind,
  output logic [orl_pkg::OUT_ADDR_W-1:0]  out_address,
  output logic [orl_pkg::CH_W-1:0]        out_value,
  input  logic                            cfg_we,
  input  logic [orl_pkg::CH_W-1:0]        cfg_wdata
);

  orl_pkg::state_t              state_r, state_nxt;
  orl_pkg::result_t             step_res;
  orl_pkg::result_t             res_r;
  logic [orl_pkg::CH_W-1:0]     sep_r;
  logic                         in_fire;

  assign in_ready = !res_r.valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  orl_step u_step (
    .state     (state_r),
    .ch        (in_ch),
    .sep       (sep_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  // Separator register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= orl_pkg::SEP_RESET;
    end else if (cfg_we) begin
      sep_r <= cfg_wdata;
    end
  end

  // Parser state: advance on each accepted character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register: load a new result, drop one that was taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (in_fire && step_res.valid) begin
      res_r <= step_res;
    end else if (out_ready) begin
      res_r.valid <= 1'b0;
    end
  end

  assign out_valid   = res_r.valid;
  assign out_kind    = res_r.kind;
  assign out_address = res_r.address;
  assign out_value   = res_r.value;

`ifndef SYNTHESIS
  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.halted |=> state_r.halted)
    else $error("halt flag cleared without reset");

  // An invalid record always halts the parser
  a_invalid_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step_res.valid && step_res.kind == orl_pkg::KIND_INVALID)
      |=> state_r.halted)
    else $error("invalid record did not halt the parser");

  // Column never passes the data field start
  a_col_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.column <= orl_pkg::COL_DATA)
    else $error("column counter past saturation");

  // No result is produced once halted
  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.halted && in_fire) |-> !step_res.valid)
    else $error("result produced while halted");
`endif

endmodule
